// ===== hw/rtl/hcawr_pkg.sv =====
`timescale 1ns / 1ps

package hcawr_pkg;

    localparam int SAMPLE_W       = 16;
    localparam int RATE_W         = 32;
    localparam int STEP_LIMIT_W   = 16;
    localparam int WINDOW_LIMIT_W = 7;
    localparam int CFG_DATA_W     = 16;
    localparam int CFG_IDX_W      = 2;
    localparam int MAX_WINDOW_DEF = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_LIMIT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LIMIT  = 2'd2;

    localparam int DIV_N_W     = 32;
    localparam int DIV_D_W     = 16;
    localparam int DIV_CNT_W   = 5;
    localparam int DIV2_STEPS  = DIV_N_W / 2;

    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] steps;
    } t_div_ctrl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP,
        ST_DIV1,
        ST_WIN,
        ST_SPAN,
        ST_DIV2,
        ST_DONE
    } t_state;

endpackage

// ===== hw/rtl/hcawr_in_if.sv =====
`timescale 1ns / 1ps

interface hcawr_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [hcawr_pkg::SAMPLE_W-1:0] count_sample;
    logic                                 restart;

    modport source (output valid, output count_sample, output restart, input ready);
    modport sink   (input valid, input count_sample, input restart, output ready);
endinterface

// ===== hw/rtl/hcawr_out_if.sv =====
`timescale 1ns / 1ps

interface hcawr_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [hcawr_pkg::RATE_W-1:0] rate_q16;

    modport source (output valid, output rate_q16, input ready);
    modport sink   (input valid, input rate_q16, output ready);
endinterface

// ===== hw/rtl/hcawr_ram.sv =====
`timescale 1ns / 1ps

module hcawr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

// ===== hw/rtl/hcawr_div.sv =====
`timescale 1ns / 1ps

module hcawr_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  hcawr_pkg::t_div_ctrl            i_ctrl,
    input  logic [hcawr_pkg::DIV_N_W-1:0]   i_num,
    input  logic [hcawr_pkg::DIV_D_W-1:0]   i_den,
    output hcawr_pkg::t_div_stat            o_stat,
    output logic [hcawr_pkg::DIV_N_W-1:0]   o_quo
);
    import hcawr_pkg::*;

    // Two restoring long-division steps per cycle, numerator taken from the top bit down.
    function automatic logic [DIV_D_W:0] div_step(input logic [DIV_D_W-1:0] rem,
                                                  input logic               nbit,
                                                  input logic [DIV_D_W-1:0] den);
        logic [DIV_D_W:0] trial;
        logic [DIV_D_W:0] diff;
        trial = {rem, nbit};
        diff  = trial - {1'b0, den};
        if (trial >= {1'b0, den}) begin
            return {1'b1, diff[DIV_D_W-1:0]};
        end
        return {1'b0, trial[DIV_D_W-1:0]};
    endfunction

    logic [DIV_N_W-1:0]   r_num;
    logic [DIV_D_W-1:0]   r_den;
    logic [DIV_D_W-1:0]   r_rem;
    logic [DIV_N_W-1:0]   r_quo;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [DIV_D_W:0]     s_st1;
    logic [DIV_D_W:0]     s_st2;

    assign s_st1 = div_step(r_rem, r_num[DIV_N_W-1], r_den);
    assign s_st2 = div_step(s_st1[DIV_D_W-1:0], r_num[DIV_N_W-2], r_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctrl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_ctrl.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[DIV_N_W-3:0], 2'b00};
            r_rem <= s_st2[DIV_D_W-1:0];
            r_quo <= {r_quo[DIV_N_W-3:0], s_st1[DIV_D_W], s_st2[DIV_D_W]};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quo       = r_quo;

endmodule

// ===== hw/rtl/hall_count_adaptive_window_rate_core.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Payload                                  Accepted when
// i_in      in         count_sample (s16), restart (1)           i_in.valid & i_in.ready
// o_out     out        rate_q16 (s32, Q16.16)                    o_out.valid & o_out.ready
// i_cfg_*   in         register index, data (16)                 i_cfg_we
//
// Raw mode and restarts go from IDLE straight to DONE, which loads the output register once
// it is free. Smooth mode runs STEP, DIV1, WIN, SPAN and DIV2 before DONE; DIV1 is skipped
// for a zero step or one at or above the limit. DIV1 and DIV2 share the two-bit-per-cycle divider.
// One item is in work at a time; the next is accepted while a result waits at the output.
// Reset clears the control and config registers and the history valid bits; unwritten history
// entries read as the last restart value, zero after reset, so no clearing pass is needed.

module hall_count_adaptive_window_rate_core #(
    parameter int MAX_WINDOW = hcawr_pkg::MAX_WINDOW_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    hcawr_in_if.sink                          i_in,
    hcawr_out_if.source                       o_out,
    input  logic                              i_cfg_we,
    input  logic [hcawr_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [hcawr_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import hcawr_pkg::*;

    localparam int DEPTH     = MAX_WINDOW + 1;
    localparam int AW        = $clog2(DEPTH);
    localparam int D1_STEPS  = (STEP_LIMIT_W + AW + 1) / 2;
    localparam int D1_SHIFT  = DIV_N_W - 2 * D1_STEPS;

    t_state                    r_state;
    t_state                    n_state;
    logic                      r_smooth;
    logic [STEP_LIMIT_W-1:0]   r_sl;
    logic [WINDOW_LIMIT_W-1:0] r_wl;
    logic [SAMPLE_W-1:0]       r_prev;
    logic [SAMPLE_W-1:0]       r_fill;
    logic [DEPTH-1:0]          r_valid;
    logic [AW-1:0]             r_head;
    logic [SAMPLE_W-1:0]       r_sample;
    logic                      r_rd_valid;
    logic [AW-1:0]             r_window;
    logic                      r_neg;
    logic [RATE_W-1:0]         r_res;
    logic                      r_out_valid;
    logic [RATE_W-1:0]         r_out_data;

    logic                      s_in_acc;
    logic                      s_out_load;
    logic [AW-1:0]             s_wl;
    logic [AW-1:0]             s_head_nx;
    logic [AW-1:0]             s_win_addr;
    logic [AW:0]               s_wrap_addr;
    logic [SAMPLE_W-1:0]       s_hist;
    logic [SAMPLE_W:0]         s_step;
    logic [SAMPLE_W-1:0]       s_dmag;
    logic [STEP_LIMIT_W-1:0]   s_sl_rem;
    logic [AW+15:0]            s_prod;
    logic [AW-1:0]             s_quo_win;
    logic [SAMPLE_W-1:0]       s_span;
    logic [SAMPLE_W-1:0]       s_span_mag;
    logic [SAMPLE_W-1:0]       s_raw_diff;

    logic                      s_ram_we;
    logic                      s_ram_re;
    logic [AW-1:0]             s_ram_raddr;
    logic [SAMPLE_W-1:0]       s_ram_rdata;

    t_div_ctrl                 s_div_ctrl;
    t_div_stat                 s_div_stat;
    logic [DIV_N_W-1:0]        s_div_num;
    logic [DIV_D_W-1:0]        s_div_den;
    logic [DIV_N_W-1:0]        s_div_quo;

    assign s_in_acc   = i_in.valid && i_in.ready;
    assign s_out_load = (r_state == ST_DONE) && (!r_out_valid || o_out.ready);

    always_comb begin
        if (r_wl == '0) begin
            s_wl = AW'(1);
        end else if (int'(r_wl) > MAX_WINDOW) begin
            s_wl = AW'(MAX_WINDOW);
        end else begin
            s_wl = AW'(r_wl);
        end
    end

    assign s_head_nx   = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign s_wrap_addr = {1'b0, r_head} + (AW+1)'(DEPTH) - {1'b0, r_window};
    assign s_win_addr  = (r_head >= r_window) ? r_head - r_window : s_wrap_addr[AW-1:0];

    assign s_hist     = r_rd_valid ? s_ram_rdata : r_fill;
    assign s_step     = {r_sample[SAMPLE_W-1], r_sample} - {s_hist[SAMPLE_W-1], s_hist};
    assign s_dmag     = s_step[SAMPLE_W] ? SAMPLE_W'(-s_step) : s_step[SAMPLE_W-1:0];
    assign s_sl_rem   = r_sl - s_dmag;
    assign s_prod     = {16'b0, s_wl} * {{AW{1'b0}}, s_sl_rem};
    assign s_quo_win  = (s_div_quo[AW-1:0] == '0) ? AW'(1) : s_div_quo[AW-1:0];
    assign s_span     = r_sample - s_hist;
    assign s_span_mag = s_span[SAMPLE_W-1] ? -s_span : s_span;
    assign s_raw_diff = i_in.count_sample - r_prev;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (s_in_acc) begin
                    if (r_smooth && !i_in.restart) begin
                        n_state = ST_STEP;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_STEP: begin
                if ((s_dmag >= r_sl) || (s_dmag == '0)) begin
                    n_state = ST_WIN;
                end else begin
                    n_state = ST_DIV1;
                end
            end
            ST_DIV1: begin
                if (s_div_stat.done) begin
                    n_state = ST_WIN;
                end
            end
            ST_WIN:  n_state = ST_SPAN;
            ST_SPAN: n_state = ST_DIV2;
            ST_DIV2: begin
                if (s_div_stat.done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (s_out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        i_in.ready       = 1'b0;
        s_ram_we         = 1'b0;
        s_ram_re         = 1'b0;
        s_ram_raddr      = r_head;
        s_div_ctrl.start = 1'b0;
        s_div_ctrl.steps = DIV_CNT_W'(DIV2_STEPS);
        s_div_num        = {s_span_mag, {(DIV_N_W-SAMPLE_W){1'b0}}};
        s_div_den        = DIV_D_W'(r_window);
        unique case (r_state)
            ST_IDLE: begin
                i_in.ready = 1'b1;
                if (s_in_acc && r_smooth && !i_in.restart) begin
                    s_ram_we = 1'b1;
                    s_ram_re = 1'b1;
                end
            end
            ST_STEP: begin
                if ((s_dmag < r_sl) && (s_dmag != '0)) begin
                    s_div_ctrl.start = 1'b1;
                end
                s_div_ctrl.steps = DIV_CNT_W'(D1_STEPS);
                s_div_num        = DIV_N_W'(s_prod) << D1_SHIFT;
                s_div_den        = r_sl;
            end
            ST_WIN: begin
                s_ram_re    = 1'b1;
                s_ram_raddr = s_win_addr;
            end
            ST_SPAN: begin
                s_div_ctrl.start = 1'b1;
            end
            ST_DIV1, ST_DIV2, ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smooth <= 1'b0;
            r_sl     <= STEP_LIMIT_W'(1);
            r_wl     <= WINDOW_LIMIT_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SMOOTH_ENABLE: r_smooth <= i_cfg_data[0];
                CFG_STEP_LIMIT:    r_sl     <= i_cfg_data[STEP_LIMIT_W-1:0];
                CFG_WINDOW_LIMIT:  r_wl     <= i_cfg_data[WINDOW_LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_prev      <= '0;
            r_fill      <= '0;
            r_valid     <= '0;
            r_head      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (s_in_acc) begin
                if (!r_smooth) begin
                    r_prev <= i_in.count_sample;
                end else if (i_in.restart) begin
                    r_fill  <= i_in.count_sample;
                    r_valid <= '0;
                end else begin
                    r_valid[s_head_nx] <= 1'b1;
                    r_head             <= s_head_nx;
                end
            end
            if (s_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_in_acc) begin
            r_sample   <= i_in.count_sample;
            r_rd_valid <= r_valid[r_head];
            if (!r_smooth && !i_in.restart) begin
                r_res <= {s_raw_diff, {(RATE_W-SAMPLE_W){1'b0}}};
            end else begin
                r_res <= '0;
            end
        end
        if (r_state == ST_STEP) begin
            if (s_dmag >= r_sl) begin
                r_window <= AW'(1);
            end else begin
                r_window <= s_wl;
            end
        end
        if ((r_state == ST_DIV1) && s_div_stat.done) begin
            r_window <= s_quo_win;
        end
        if (r_state == ST_WIN) begin
            r_rd_valid <= r_valid[s_win_addr];
        end
        if (r_state == ST_SPAN) begin
            r_neg <= s_span[SAMPLE_W-1];
        end
        if ((r_state == ST_DIV2) && s_div_stat.done) begin
            r_res <= r_neg ? -s_div_quo : s_div_quo;
        end
        if (s_out_load) begin
            r_out_data <= r_res;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.rate_q16 = r_out_data;

    hcawr_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (DEPTH)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (s_ram_we),
        .i_waddr (s_head_nx),
        .i_wdata (i_in.count_sample),
        .i_re    (s_ram_re),
        .i_raddr (s_ram_raddr),
        .o_rdata (s_ram_rdata)
    );

    hcawr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (s_div_ctrl),
        .i_num   (s_div_num),
        .i_den   (s_div_den),
        .o_stat  (s_div_stat),
        .o_quo   (s_div_quo)
    );

    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_div_ctrl.start |-> !s_div_stat.busy)
        else $error("divider started while busy");

    a_window_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WIN) |-> ((r_window != '0) && (int'(r_window) <= MAX_WINDOW)))
        else $error("window out of range");

    a_win_addr_not_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WIN) |-> (s_win_addr != r_head))
        else $error("window read hits the newest entry");

    a_head_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_head) < DEPTH)
        else $error("history pointer out of range");

    a_head_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_in_acc && r_smooth && !i_in.restart) |=> (r_head != $past(r_head)))
        else $error("history pointer did not advance");

endmodule
